@@ design/msch_pkg.sv @@
// ----------------------------------------------------------------------------
// msch_pkg
// shared constants, codes and lookup functions for the task scheduler
// ----------------------------------------------------------------------------
package msch_pkg;

    localparam int KIND_W   = 2;
    localparam int ID_W     = 12;
    localparam int LVL_W    = 3;
    localparam int SPENT_W  = 48;
    localparam int USED_W   = 40;
    localparam int STATUS_W = 3;
    localparam int US_W     = 48;
    localparam int WGT_W    = 17;
    localparam int MUL_A_W  = 32;
    localparam int MUL_P_W  = MUL_A_W + WGT_W;
    localparam int TRI_W    = 8;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_kind KIND_SUBMIT = 2'd0;
    localparam t_kind KIND_TAKE   = 2'd1;
    localparam t_kind KIND_UPDATE = 2'd2;
    localparam t_kind KIND_FINISH = 2'd3;

    localparam t_status ST_QUEUED  = 3'd0;
    localparam t_status ST_DROPPED = 3'd1;
    localparam t_status ST_FULL    = 3'd2;
    localparam t_status ST_TAKEN   = 3'd3;
    localparam t_status ST_NONE    = 3'd4;
    localparam t_status ST_DONE    = 3'd5;

    localparam logic [9:0] US_DIV = 10'd1000;

    // floor(2^26 / 1000), always an underestimate of the quotient
    localparam logic [WGT_W-1:0] US_RECIP = 17'd67108;

    // q1.16 reciprocal of 1.2 to the power k
    function automatic logic [WGT_W-1:0] level_weight(input logic [3:0] k);
        logic [WGT_W-1:0] w;
        case (k)
            4'd0:    w = 17'd65536;
            4'd1:    w = 17'd54613;
            4'd2:    w = 17'd45511;
            4'd3:    w = 17'd37926;
            4'd4:    w = 17'd31605;
            4'd5:    w = 17'd26337;
            4'd6:    w = 17'd21948;
            4'd7:    w = 17'd18290;
            4'd8:    w = 17'd15242;
            4'd9:    w = 17'd12701;
            4'd10:   w = 17'd10584;
            4'd11:   w = 17'd8820;
            4'd12:   w = 17'd7350;
            4'd13:   w = 17'd6125;
            4'd14:   w = 17'd5104;
            4'd15:   w = 17'd4254;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

    // cumulative slice multiple (i+1)(i+2)/2
    function automatic logic [TRI_W-1:0] tri_mult(input logic [3:0] i);
        logic [9:0] p;
        p = (10'(i) + 10'd1) * (10'(i) + 10'd2);
        return p[8:1];
    endfunction

endpackage

@@ design/msch_mul.sv @@
// ----------------------------------------------------------------------------
// msch_mul
// shared registered multiplier, 32 x 17 bits
// ----------------------------------------------------------------------------
module msch_mul (
    input  logic                            i_clk,
    input  logic [msch_pkg::MUL_A_W-1:0]    i_a,
    input  logic [msch_pkg::WGT_W-1:0]      i_b,
    output logic [msch_pkg::MUL_P_W-1:0]    o_prod
);

    logic [msch_pkg::MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= msch_pkg::MUL_P_W'(i_a) * msch_pkg::MUL_P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ design/msch_store.sv @@
// ----------------------------------------------------------------------------
// msch_store
// task id store, one write and one registered read port
// ----------------------------------------------------------------------------
module msch_store #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [msch_pkg::ID_W-1:0]   i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [msch_pkg::ID_W-1:0]   o_rdata
);

    logic [msch_pkg::ID_W-1:0] r_mem [DEPTH];
    logic [msch_pkg::ID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/multilevel_feedback_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// multilevel_feedback_task_scheduler
// multilevel feedback queue of task ids with weighted level selection
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | tuser: kind; tdata: task_id, task_level, time_spent_ns,
//            |           |   consumed_ns (lowest bits first)
//  m_axis    | out       | tuser: status; tdata: out_task_id, out_level
//  i_cfg_*   | in        | slice_base_ns write
//
//  submit: tests levels in turn from the start level, then enqueues
//  take: weighs each non-empty level (two halves on the shared multiplier,
//    then combine and compare), skips empty levels, then reads the store
//  update: division by 1000 on the shared multiplier (two reciprocal passes
//    and a final compare), then the level's consumed time is updated
//  one request at a time; s_axis_tready is low while busy or while the
//  result waits on m_axis. reset is synchronous, active low
// ----------------------------------------------------------------------------
module multilevel_feedback_task_scheduler #(
    parameter int LEVELS     = 8,
    parameter int FIFO_DEPTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_wdata,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [1:0]      s_axis_tuser,   // kind
    input  logic [103:0]    s_axis_tdata,   // task_id, task_level, time_spent_ns, consumed_ns
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [2:0]      m_axis_tuser,   // status
    output logic [15:0]     m_axis_tdata    // out_task_id, out_level
);

    localparam int LW    = $clog2(LEVELS);
    localparam int HW    = $clog2(FIFO_DEPTH);
    localparam int CW    = $clog2(FIFO_DEPTH + 1);
    localparam int PW    = CW + 1;
    localparam int DEPTH = LEVELS * FIFO_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = msch_pkg::MUL_P_W + 24;

    localparam logic [LW-1:0] LAST_LVL = LW'(LEVELS - 1);
    localparam logic [AW-1:0] DEP_A    = AW'(FIFO_DEPTH);
    localparam logic [PW-1:0] DEP_P    = PW'(FIFO_DEPTH);
    localparam logic [CW-1:0] DEP_C    = CW'(FIFO_DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUB  = 3'd1;
    localparam logic [2:0] S_ENQ  = 3'd2;
    localparam logic [2:0] S_TAKE = 3'd3;
    localparam logic [2:0] S_PICK = 3'd4;
    localparam logic [2:0] S_READ = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_UPD  = 3'd7;

    logic [2:0]     r_state;
    logic [31:0]    r_slice;
    logic           r_fin;

    // captured request
    logic [msch_pkg::ID_W-1:0]      r_id;
    logic [msch_pkg::SPENT_W-1:0]   r_spent;

    // level state
    logic [HW-1:0]              r_head [LEVELS];
    logic [CW-1:0]              r_count [LEVELS];
    logic [msch_pkg::US_W-1:0]  r_cons [LEVELS];

    // iteration
    logic [LW-1:0]  r_idx;
    logic [1:0]     r_ph;
    logic           r_best_vld;
    logic [LW-1:0]  r_best;
    logic [TW-1:0]  r_best_t;
    logic [40:0]    r_lo;

    // divider
    logic [msch_pkg::USED_W-1:0]    r_quo;
    logic [msch_pkg::USED_W-1:0]    r_rem;
    logic [msch_pkg::MUL_P_W-1:0]   r_dlo;
    logic [msch_pkg::MUL_A_W-1:0]   r_dest;
    logic [2:0]                     r_dcnt;
    logic                           r_dpass;

    // result register
    logic                           r_out_valid;
    msch_pkg::t_status              r_out_status;
    logic [msch_pkg::ID_W-1:0]      r_out_id;
    logic [2:0]                     r_out_lvl;

    // input fields
    msch_pkg::t_kind                in_kind;
    logic [msch_pkg::ID_W-1:0]      in_id;
    logic [msch_pkg::LVL_W-1:0]     in_lvl;
    logic [msch_pkg::SPENT_W-1:0]   in_spent;
    logic [msch_pkg::USED_W-1:0]    in_used;
    logic                           accept;

    assign in_kind  = s_axis_tuser;
    assign in_id    = s_axis_tdata[11:0];
    assign in_lvl   = s_axis_tdata[14:12];
    assign in_spent = s_axis_tdata[62:15];
    assign in_used  = s_axis_tdata[102:63];

    assign s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // shared multiplier operands
    logic [msch_pkg::MUL_A_W-1:0]   mul_a;
    logic [msch_pkg::WGT_W-1:0]     mul_b;
    logic [msch_pkg::MUL_P_W-1:0]   mul_p;

    always_comb begin
        if (r_state == S_SUB) begin
            mul_a = r_slice;
            mul_b = msch_pkg::WGT_W'(msch_pkg::tri_mult(4'(r_idx)));
        end else if (r_state == S_DIV) begin
            // remainder times reciprocal in two halves, then estimate times 1000
            mul_b = msch_pkg::US_RECIP;
            case (r_dcnt)
                3'd0: begin
                    mul_a = r_rem[31:0];
                end
                3'd1: begin
                    mul_a = msch_pkg::MUL_A_W'(r_rem[39:32]);
                end
                3'd3: begin
                    mul_a = r_dest;
                    mul_b = msch_pkg::WGT_W'(msch_pkg::US_DIV);
                end
                default: begin
                    mul_a = r_rem[31:0];
                end
            endcase
        end else if (r_ph == 2'd0) begin
            mul_a = msch_pkg::MUL_A_W'(r_cons[r_idx][23:0]);
            mul_b = msch_pkg::level_weight(4'(LEVELS - 1) - 4'(r_idx));
        end else begin
            mul_a = msch_pkg::MUL_A_W'(r_cons[r_idx][47:24]);
            mul_b = msch_pkg::level_weight(4'(LEVELS - 1) - 4'(r_idx));
        end
    end

    msch_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    // store ports
    logic [PW-1:0]              tail_sum;
    logic [HW-1:0]              tail;
    logic [AW-1:0]              waddr;
    logic [AW-1:0]              raddr;
    logic                       we;
    logic [msch_pkg::ID_W-1:0]  rdata;

    always_comb begin
        tail_sum = PW'(r_head[r_idx]) + PW'(r_count[r_idx]);
        if (tail_sum >= DEP_P) begin
            tail_sum = tail_sum - DEP_P;
        end
        tail  = HW'(tail_sum);
        waddr = AW'(r_idx) * DEP_A + AW'(tail);
        raddr = AW'(r_best) * DEP_A + AW'(r_head[r_best]);
        we    = (r_state == S_ENQ) && (r_count[r_idx] != DEP_C);
    end

    msch_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_id),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // weighted time of the current level, hi half on the multiplier now
    logic [TW-1:0]  cur_t;
    logic [57:0]    div_sum;
    logic [31:0]    div_est;
    logic [msch_pkg::US_W:0] upd_sum;

    assign cur_t     = TW'({mul_p[40:0], 24'd0}) + TW'(r_lo);
    // quotient estimate: (hi * recip << 32 + lo * recip) >> 26
    assign div_sum   = 58'({mul_p[24:0], 32'd0}) + 58'(r_dlo);
    assign div_est   = div_sum[57:26];
    assign upd_sum   = (msch_pkg::US_W + 1)'(r_cons[r_idx]) + (msch_pkg::US_W + 1)'(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slice     <= 32'd1000000;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
            r_ph        <= 2'd0;
            r_best_vld  <= 1'b0;
            r_dcnt      <= 3'd0;
            r_dpass     <= 1'b0;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l]  <= '0;
                r_count[l] <= '0;
                r_cons[l]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_slice <= i_cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_id         <= in_id;
                        r_spent      <= in_spent;
                        r_out_status <= msch_pkg::ST_DONE;
                        r_out_id     <= '0;
                        r_out_lvl    <= '0;
                        r_ph         <= 2'd0;
                        r_best_vld   <= 1'b0;
                        case (in_kind)
                            msch_pkg::KIND_SUBMIT: begin
                                if (r_fin) begin
                                    r_out_status <= msch_pkg::ST_DROPPED;
                                    r_out_id     <= in_id;
                                    r_out_valid  <= 1'b1;
                                end else if (32'(in_lvl) >= 32'(LEVELS)) begin
                                    r_idx   <= LAST_LVL;
                                    r_state <= S_ENQ;
                                end else begin
                                    r_idx   <= LW'(in_lvl);
                                    r_state <= S_SUB;
                                end
                            end
                            msch_pkg::KIND_TAKE: begin
                                if (r_fin) begin
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_idx   <= '0;
                                    r_state <= S_TAKE;
                                end
                            end
                            msch_pkg::KIND_UPDATE: begin
                                if (32'(in_lvl) >= 32'(LEVELS)) begin
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_idx   <= LW'(in_lvl);
                                    r_quo   <= '0;
                                    r_rem   <= in_used;
                                    r_dcnt  <= 3'd0;
                                    r_dpass <= 1'b0;
                                    r_state <= S_DIV;
                                end
                            end
                            default: begin
                                r_fin       <= 1'b1;
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end

                // threshold product issued in phase 0, compared in phase 1
                S_SUB: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        if ((msch_pkg::MUL_P_W'(r_spent) < mul_p) || (r_idx == LAST_LVL)) begin
                            r_state <= S_ENQ;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end

                S_ENQ: begin
                    r_out_id    <= r_id;
                    r_out_lvl   <= 3'(r_idx);
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                    if (r_count[r_idx] == DEP_C) begin
                        r_out_status <= msch_pkg::ST_FULL;
                    end else begin
                        r_out_status   <= msch_pkg::ST_QUEUED;
                        r_count[r_idx] <= r_count[r_idx] + 1'b1;
                    end
                end

                // low half, high half, then combine and compare; empty levels are skipped
                S_TAKE: begin
                    if ((r_count[r_idx] == '0) || (r_ph == 2'd2)) begin
                        if ((r_count[r_idx] != '0) && (!r_best_vld || (cur_t < r_best_t))) begin
                            r_best_vld <= 1'b1;
                            r_best     <= r_idx;
                            r_best_t   <= cur_t;
                        end
                        r_ph <= 2'd0;
                        if (r_idx == LAST_LVL) begin
                            r_state <= S_PICK;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        if (r_ph == 2'd1) begin
                            r_lo <= mul_p[40:0];
                        end
                        r_ph <= r_ph + 2'd1;
                    end
                end

                S_PICK: begin
                    if (r_best_vld) begin
                        r_state <= S_READ;
                    end else begin
                        r_out_status <= msch_pkg::ST_NONE;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end

                S_READ: begin
                    r_out_status    <= msch_pkg::ST_TAKEN;
                    r_out_id        <= rdata;
                    r_out_lvl       <= 3'(r_best);
                    r_out_valid     <= 1'b1;
                    r_count[r_best] <= r_count[r_best] - 1'b1;
                    if (PW'(r_head[r_best]) + PW'(1) >= DEP_P) begin
                        r_head[r_best] <= '0;
                    end else begin
                        r_head[r_best] <= r_head[r_best] + 1'b1;
                    end
                    r_state <= S_IDLE;
                end

                // division by 1000: each pass takes an underestimated quotient
                // off the remainder, after two passes it is below 2000
                S_DIV: begin
                    case (r_dcnt)
                        3'd1: begin
                            r_dlo  <= mul_p;
                            r_dcnt <= 3'd2;
                        end
                        3'd2: begin
                            r_dest <= div_est;
                            r_quo  <= r_quo + msch_pkg::USED_W'(div_est);
                            r_dcnt <= 3'd3;
                        end
                        3'd4: begin
                            r_rem <= r_rem - mul_p[msch_pkg::USED_W-1:0];
                            if (r_dpass) begin
                                r_dcnt <= 3'd5;
                            end else begin
                                r_dpass <= 1'b1;
                                r_dcnt  <= 3'd0;
                            end
                        end
                        3'd5: begin
                            if (r_rem >= msch_pkg::USED_W'(msch_pkg::US_DIV)) begin
                                r_quo <= r_quo + msch_pkg::USED_W'(1);
                            end
                            r_state <= S_UPD;
                        end
                        default: begin
                            r_dcnt <= r_dcnt + 3'd1;
                        end
                    endcase
                end

                S_UPD: begin
                    if (upd_sum[msch_pkg::US_W]) begin
                        r_cons[r_idx] <= '1;
                    end else begin
                        r_cons[r_idx] <= upd_sum[msch_pkg::US_W-1:0];
                    end
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0, r_out_lvl, r_out_id};

endmodule
